@@ rtl/source_code_tokenizer_assert.svh @@
// assertion macros for the source code tokenizer
// no dependencies; taken in by the top level
`ifndef SOURCE_CODE_TOKENIZER_ASSERT_SVH
`define SOURCE_CODE_TOKENIZER_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define SCT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sct assertion failed");
// next-cycle implication
`define SCT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sct assertion failed");
`else
`define SCT_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SCT_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ rtl/sct_pkg.sv @@
// shared types, codes and helper functions for the source code tokenizer
// no dependencies; used by every other file but the assert header and the byte interface
package sct_pkg;

	localparam int DEF_OFFSET_WIDTH = 24;
	localparam int DEF_LINE_WIDTH   = 20;
	localparam int DEF_COLUMN_WIDTH = 16;

	localparam int KIND_W = 5;
	localparam int ERR_W  = 2;
	localparam int TEXT_W = 24;
	localparam int LINE_W = 20;
	localparam int COL_W  = 16;

	localparam int MAX_RESULTS = 3;
	localparam int QUEUE_DEPTH = 8;

	// scanner modes
	typedef enum logic [3:0] {
		M_IDLE      = 4'd0,
		M_IDENT     = 4'd1,
		M_NUMBER    = 4'd2,
		M_DIRECTIVE = 4'd3,
		M_LABEL     = 4'd4,
		M_STRING    = 4'd5,
		M_MINUS     = 4'd6,
		M_SLASH     = 4'd7,
		M_LINECMT   = 4'd8,
		M_BLOCKCMT  = 4'd9,
		M_BLOCKSTAR = 4'd10,
		M_ERRCHAR   = 4'd11,
		M_ERRSTR    = 4'd12
	} mode_t;

	// token kinds
	localparam logic [KIND_W-1:0] K_IDENT     = 5'd0;
	localparam logic [KIND_W-1:0] K_RETURN    = 5'd1;
	localparam logic [KIND_W-1:0] K_NUMBER    = 5'd2;
	localparam logic [KIND_W-1:0] K_STRING    = 5'd3;
	localparam logic [KIND_W-1:0] K_DIRECTIVE = 5'd4;
	localparam logic [KIND_W-1:0] K_LABEL     = 5'd5;
	localparam logic [KIND_W-1:0] K_ARROW     = 5'd6;
	localparam logic [KIND_W-1:0] K_SEMI      = 5'd7;
	localparam logic [KIND_W-1:0] K_COLON     = 5'd8;
	localparam logic [KIND_W-1:0] K_LPAREN    = 5'd9;
	localparam logic [KIND_W-1:0] K_RPAREN    = 5'd10;
	localparam logic [KIND_W-1:0] K_LBRACE    = 5'd11;
	localparam logic [KIND_W-1:0] K_RBRACE    = 5'd12;
	localparam logic [KIND_W-1:0] K_EQUAL     = 5'd13;
	localparam logic [KIND_W-1:0] K_PLUS      = 5'd14;
	localparam logic [KIND_W-1:0] K_MINUS     = 5'd15;
	localparam logic [KIND_W-1:0] K_STAR      = 5'd16;
	localparam logic [KIND_W-1:0] K_SLASH     = 5'd17;
	localparam logic [KIND_W-1:0] K_COMMA     = 5'd18;
	localparam logic [KIND_W-1:0] K_END       = 5'd19;

	// error codes
	localparam logic [ERR_W-1:0] ERR_NONE   = 2'd0;
	localparam logic [ERR_W-1:0] ERR_CHAR   = 2'd1;
	localparam logic [ERR_W-1:0] ERR_STRING = 2'd2;

	// keyword tracking
	localparam logic [2:0] KW_LEN  = 3'd6;
	localparam logic [2:0] KW_NONE = 3'd7;

	// characters
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NL      = 8'h0A;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_QUOTE   = 8'h22;
	localparam logic [7:0] CH_HASH    = 8'h23;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_STAR    = 8'h2A;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_DOT     = 8'h2E;
	localparam logic [7:0] CH_SLASH   = 8'h2F;
	localparam logic [7:0] CH_0       = 8'h30;
	localparam logic [7:0] CH_9       = 8'h39;
	localparam logic [7:0] CH_COLON   = 8'h3A;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_EQUAL   = 8'h3D;
	localparam logic [7:0] CH_GT      = 8'h3E;
	localparam logic [7:0] CH_AT      = 8'h40;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_USCORE  = 8'h5F;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;
	localparam logic [7:0] CH_LBRACE  = 8'h7B;
	localparam logic [7:0] CH_RBRACE  = 8'h7D;
	localparam logic [7:0] CH_E       = 8'h65;
	localparam logic [7:0] CH_N       = 8'h6E;
	localparam logic [7:0] CH_R       = 8'h72;
	localparam logic [7:0] CH_T       = 8'h74;
	localparam logic [7:0] CH_U       = 8'h75;

	typedef struct packed {
		logic [KIND_W-1:0] token_kind;
		logic [ERR_W-1:0]  error_code;
		logic [LINE_W-1:0] token_line;
		logic [COL_W-1:0]  token_column;
		logic [TEXT_W-1:0] text_offset;
		logic [TEXT_W-1:0] text_length;
		logic              last_of_run;
	} res_t;

	// results of one byte, written to the queue together
	typedef struct packed {
		res_t [MAX_RESULTS-1:0] item;
		logic [1:0]             count;
	} push_t;

	typedef struct packed {
		mode_t mode;
		logic  err;
	} stat_t;

	function automatic logic is_alpha(logic [7:0] c);
		return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z);
	endfunction

	function automatic logic is_digit(logic [7:0] c);
		return c >= CH_0 && c <= CH_9;
	endfunction

	function automatic logic is_word(logic [7:0] c);
		return is_alpha(c) || is_digit(c) || c == CH_USCORE;
	endfunction

	function automatic logic is_symbol(logic [7:0] c);
		return c == CH_SEMI || c == CH_COLON || c == CH_LPAREN || c == CH_RPAREN ||
			c == CH_LBRACE || c == CH_RBRACE || c == CH_EQUAL || c == CH_PLUS ||
			c == CH_STAR || c == CH_COMMA;
	endfunction

	function automatic logic [KIND_W-1:0] sym_kind(logic [7:0] c);
		logic [KIND_W-1:0] k;
		unique case (c)
			CH_SEMI:   k = K_SEMI;
			CH_COLON:  k = K_COLON;
			CH_LPAREN: k = K_LPAREN;
			CH_RPAREN: k = K_RPAREN;
			CH_LBRACE: k = K_LBRACE;
			CH_RBRACE: k = K_RBRACE;
			CH_EQUAL:  k = K_EQUAL;
			CH_PLUS:   k = K_PLUS;
			CH_STAR:   k = K_STAR;
			CH_COMMA:  k = K_COMMA;
			default:   k = K_END;
		endcase
		return k;
	endfunction

	// letters of the keyword "return"
	function automatic logic [7:0] kw_char(logic [2:0] idx);
		logic [7:0] ch;
		unique case (idx)
			3'd0:    ch = CH_R;
			3'd1:    ch = CH_E;
			3'd2:    ch = CH_T;
			3'd3:    ch = CH_U;
			3'd4:    ch = CH_R;
			3'd5:    ch = CH_N;
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	function automatic logic is_pending(mode_t md);
		return md == M_IDENT || md == M_NUMBER || md == M_DIRECTIVE || md == M_LABEL ||
			md == M_MINUS || md == M_SLASH;
	endfunction

	function automatic logic [KIND_W-1:0] pending_kind(mode_t md, logic [2:0] kw);
		logic [KIND_W-1:0] k;
		unique case (md)
			M_IDENT:     k = (kw == KW_LEN) ? K_RETURN : K_IDENT;
			M_NUMBER:    k = K_NUMBER;
			M_DIRECTIVE: k = K_DIRECTIVE;
			M_LABEL:     k = K_LABEL;
			M_MINUS:     k = K_MINUS;
			M_SLASH:     k = K_SLASH;
			default:     k = K_IDENT;
		endcase
		return k;
	endfunction

	function automatic logic [TEXT_W-1:0] cap_off(logic [31:0] v);
		return (v > 32'({TEXT_W{1'b1}})) ? {TEXT_W{1'b1}} : v[TEXT_W-1:0];
	endfunction

	function automatic logic [LINE_W-1:0] cap_line(logic [31:0] v);
		return (v > 32'({LINE_W{1'b1}})) ? {LINE_W{1'b1}} : v[LINE_W-1:0];
	endfunction

	function automatic logic [COL_W-1:0] cap_col(logic [31:0] v);
		return (v > 32'({COL_W{1'b1}})) ? {COL_W{1'b1}} : v[COL_W-1:0];
	endfunction

	function automatic res_t mk_res(logic [KIND_W-1:0] kind, logic [ERR_W-1:0] code,
		logic [LINE_W-1:0] line, logic [COL_W-1:0] col,
		logic [TEXT_W-1:0] off, logic [TEXT_W-1:0] len);
		res_t r;
		r.token_kind   = kind;
		r.error_code   = code;
		r.token_line   = line;
		r.token_column = col;
		r.text_offset  = off;
		r.text_length  = len;
		r.last_of_run  = 1'b0;
		return r;
	endfunction

endpackage

@@ rtl/sct_byte_if.sv @@
// input channel of the source code tokenizer: one source byte per transaction
// no dependencies
interface sct_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] source_byte;
	logic       end_of_source;

	modport source (output valid, output source_byte, output end_of_source, input ready);
	modport sink (input valid, input source_byte, input end_of_source, output ready);
endinterface

@@ rtl/sct_token_if.sv @@
// output channel of the source code tokenizer: one token record per transaction
// depends on sct_pkg
interface sct_token_if;
	logic                              valid;
	logic                              ready;
	logic [sct_pkg::KIND_W-1:0]        token_kind;
	logic [sct_pkg::ERR_W-1:0]         error_code;
	logic [sct_pkg::LINE_W-1:0]        token_line;
	logic [sct_pkg::COL_W-1:0]         token_column;
	logic [sct_pkg::TEXT_W-1:0]        text_offset;
	logic [sct_pkg::TEXT_W-1:0]        text_length;
	logic                              last_of_run;

	modport source (output valid, output token_kind, output error_code, output token_line,
		output token_column, output text_offset, output text_length, output last_of_run,
		input ready);
	modport sink (input valid, input token_kind, input error_code, input token_line,
		input token_column, input text_offset, input text_length, input last_of_run,
		output ready);
endinterface

@@ rtl/sct_scan.sv @@
// scanner state and the per-byte step logic; produces up to three records per byte
// depends on sct_pkg
module sct_scan #(
	parameter int OFFSET_WIDTH = sct_pkg::DEF_OFFSET_WIDTH,
	parameter int LINE_WIDTH   = sct_pkg::DEF_LINE_WIDTH,
	parameter int COLUMN_WIDTH = sct_pkg::DEF_COLUMN_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                fire,
	input  logic [7:0]          source_byte,
	input  logic                end_of_source,
	output sct_pkg::push_t      push,
	output sct_pkg::stat_t      stat
);

	sct_pkg::mode_t          mode_q;
	logic [OFFSET_WIDTH-1:0] byte_off_q, st_off_q;
	logic [LINE_WIDTH-1:0]   cur_line_q, st_line_q;
	logic [COLUMN_WIDTH-1:0] cur_col_q, st_col_q;
	logic [2:0]              kw_q;
	logic                    pbs_q, err_q;

	sct_pkg::mode_t          mode_d;
	logic [OFFSET_WIDTH-1:0] byte_off_d, st_off_d;
	logic [LINE_WIDTH-1:0]   cur_line_d, st_line_d;
	logic [COLUMN_WIDTH-1:0] cur_col_d, st_col_d;
	logic [2:0]              kw_d;
	logic                    pbs_d, err_d;
	sct_pkg::res_t [sct_pkg::MAX_RESULTS-1:0] res;
	logic [1:0]              n;

	// record of a pending word-like token or a lone '-' or '/'
	function automatic sct_pkg::res_t fin_res(sct_pkg::mode_t md, logic [2:0] kwv,
		logic [LINE_WIDTH-1:0] lnv, logic [COLUMN_WIDTH-1:0] clv,
		logic [OFFSET_WIDTH-1:0] sov, logic [OFFSET_WIDTH-1:0] endv);
		logic [OFFSET_WIDTH-1:0] len;
		logic [sct_pkg::KIND_W-1:0] kind;
		len  = (endv >= sov) ? endv - sov : '0;
		kind = sct_pkg::pending_kind(md, kwv);
		if (md == sct_pkg::M_MINUS || md == sct_pkg::M_SLASH) begin
			return sct_pkg::mk_res(kind, sct_pkg::ERR_NONE, sct_pkg::cap_line(32'(lnv)),
				sct_pkg::cap_col(32'(clv)), '0, '0);
		end
		return sct_pkg::mk_res(kind, sct_pkg::ERR_NONE, sct_pkg::cap_line(32'(lnv)),
			sct_pkg::cap_col(32'(clv)), sct_pkg::cap_off(32'(sov)), sct_pkg::cap_off(32'(len)));
	endfunction

	always_comb begin
		logic                    redo, fin;
		logic [OFFSET_WIDTH-1:0] pos, len;
		logic [sct_pkg::ERR_W-1:0] code;
		mode_d     = mode_q;
		byte_off_d = byte_off_q;
		cur_line_d = cur_line_q;
		cur_col_d  = cur_col_q;
		st_off_d   = st_off_q;
		st_line_d  = st_line_q;
		st_col_d   = st_col_q;
		kw_d       = kw_q;
		pbs_d      = pbs_q;
		err_d      = err_q;
		res        = '0;
		n          = 2'd0;
		redo       = 1'b0;
		fin        = 1'b0;
		pos        = byte_off_q;
		len        = (byte_off_q >= st_off_q) ? byte_off_q - st_off_q : '0;
		code       = sct_pkg::ERR_NONE;

		if (!err_q) begin
			unique case (mode_q)
				sct_pkg::M_IDLE: begin
					redo = 1'b1;
				end
				sct_pkg::M_IDENT: begin
					if (sct_pkg::is_word(source_byte)) begin
						if (kw_q < sct_pkg::KW_LEN && source_byte == sct_pkg::kw_char(kw_q))
							kw_d = kw_q + 3'd1;
						else
							kw_d = sct_pkg::KW_NONE;
					end else begin
						fin  = 1'b1;
						redo = 1'b1;
					end
				end
				sct_pkg::M_NUMBER: begin
					if (!(sct_pkg::is_digit(source_byte) || source_byte == sct_pkg::CH_DOT)) begin
						fin  = 1'b1;
						redo = 1'b1;
					end
				end
				sct_pkg::M_DIRECTIVE, sct_pkg::M_LABEL: begin
					if (!sct_pkg::is_word(source_byte)) begin
						fin  = 1'b1;
						redo = 1'b1;
					end
				end
				sct_pkg::M_STRING: begin
					if (source_byte == sct_pkg::CH_QUOTE) begin
						res[n] = sct_pkg::mk_res(sct_pkg::K_STRING, sct_pkg::ERR_NONE,
							sct_pkg::cap_line(32'(st_line_q)), sct_pkg::cap_col(32'(st_col_q)),
							sct_pkg::cap_off(32'(st_off_q)), sct_pkg::cap_off(32'(len)));
						n      = n + 2'd1;
						mode_d = sct_pkg::M_IDLE;
					end else if (source_byte == sct_pkg::CH_NL && !pbs_q) begin
						res[n] = sct_pkg::mk_res(sct_pkg::K_END, sct_pkg::ERR_STRING,
							sct_pkg::cap_line(32'(st_line_q)), sct_pkg::cap_col(32'(st_col_q)),
							'0, '0);
						n      = n + 2'd1;
						mode_d = sct_pkg::M_ERRSTR;
						err_d  = 1'b1;
					end else begin
						pbs_d = (source_byte == sct_pkg::CH_BSLASH);
					end
				end
				sct_pkg::M_MINUS: begin
					if (source_byte == sct_pkg::CH_GT) begin
						res[n] = sct_pkg::mk_res(sct_pkg::K_ARROW, sct_pkg::ERR_NONE,
							sct_pkg::cap_line(32'(st_line_q)), sct_pkg::cap_col(32'(st_col_q)),
							'0, '0);
						n      = n + 2'd1;
						mode_d = sct_pkg::M_IDLE;
					end else begin
						fin  = 1'b1;
						redo = 1'b1;
					end
				end
				sct_pkg::M_SLASH: begin
					if (source_byte == sct_pkg::CH_SLASH) begin
						mode_d = sct_pkg::M_LINECMT;
					end else if (source_byte == sct_pkg::CH_STAR) begin
						mode_d = sct_pkg::M_BLOCKCMT;
					end else begin
						fin  = 1'b1;
						redo = 1'b1;
					end
				end
				sct_pkg::M_LINECMT: begin
					if (source_byte == sct_pkg::CH_NL)
						mode_d = sct_pkg::M_IDLE;
				end
				sct_pkg::M_BLOCKCMT: begin
					if (source_byte == sct_pkg::CH_STAR)
						mode_d = sct_pkg::M_BLOCKSTAR;
				end
				sct_pkg::M_BLOCKSTAR: begin
					if (source_byte == sct_pkg::CH_SLASH)
						mode_d = sct_pkg::M_IDLE;
					else if (source_byte != sct_pkg::CH_STAR)
						mode_d = sct_pkg::M_BLOCKCMT;
				end
				default: begin
					mode_d = sct_pkg::M_IDLE;
					redo   = 1'b1;
				end
			endcase

			// flush the token that this byte ends
			if (fin) begin
				res[n] = fin_res(mode_q, kw_q, st_line_q, st_col_q, st_off_q, pos);
				n      = n + 2'd1;
				mode_d = sct_pkg::M_IDLE;
			end

			// start of something new
			if (redo) begin
				priority if (source_byte == sct_pkg::CH_SPACE || source_byte == sct_pkg::CH_TAB ||
					source_byte == sct_pkg::CH_NL) begin
					mode_d = sct_pkg::M_IDLE;
				end else if (source_byte == sct_pkg::CH_HASH || source_byte == sct_pkg::CH_AT ||
					source_byte == sct_pkg::CH_QUOTE) begin
					mode_d = (source_byte == sct_pkg::CH_HASH) ? sct_pkg::M_DIRECTIVE :
						(source_byte == sct_pkg::CH_AT) ? sct_pkg::M_LABEL : sct_pkg::M_STRING;
					st_line_d = cur_line_q;
					st_col_d  = cur_col_q;
					st_off_d  = (&pos) ? pos : pos + 1'b1;
					if (source_byte == sct_pkg::CH_QUOTE)
						pbs_d = 1'b0;
				end else if (source_byte == sct_pkg::CH_MINUS ||
					source_byte == sct_pkg::CH_SLASH) begin
					mode_d    = (source_byte == sct_pkg::CH_MINUS) ? sct_pkg::M_MINUS :
						sct_pkg::M_SLASH;
					st_line_d = cur_line_q;
					st_col_d  = cur_col_q;
					st_off_d  = pos;
				end else if (sct_pkg::is_symbol(source_byte)) begin
					res[n] = sct_pkg::mk_res(sct_pkg::sym_kind(source_byte), sct_pkg::ERR_NONE,
						sct_pkg::cap_line(32'(cur_line_q)), sct_pkg::cap_col(32'(cur_col_q)),
						'0, '0);
					n      = n + 2'd1;
					mode_d = sct_pkg::M_IDLE;
				end else if (sct_pkg::is_alpha(source_byte) || sct_pkg::is_digit(source_byte)) begin
					mode_d    = sct_pkg::is_alpha(source_byte) ? sct_pkg::M_IDENT :
						sct_pkg::M_NUMBER;
					st_line_d = cur_line_q;
					st_col_d  = cur_col_q;
					st_off_d  = pos;
					if (sct_pkg::is_alpha(source_byte))
						kw_d = (source_byte == sct_pkg::kw_char(3'd0)) ? 3'd1 : sct_pkg::KW_NONE;
				end else begin
					res[n] = sct_pkg::mk_res(sct_pkg::K_END, sct_pkg::ERR_CHAR,
						sct_pkg::cap_line(32'(cur_line_q)), sct_pkg::cap_col(32'(cur_col_q)),
						'0, '0);
					n      = n + 2'd1;
					mode_d = sct_pkg::M_ERRCHAR;
					err_d  = 1'b1;
				end
			end

			// position counters, saturating
			byte_off_d = (&byte_off_q) ? byte_off_q : byte_off_q + 1'b1;
			if (source_byte == sct_pkg::CH_NL) begin
				cur_line_d = (&cur_line_q) ? cur_line_q : cur_line_q + 1'b1;
				cur_col_d  = '0;
			end else begin
				cur_col_d  = (&cur_col_q) ? cur_col_q : cur_col_q + 1'b1;
			end
		end

		if (end_of_source) begin
			if (!err_d) begin
				if (mode_d == sct_pkg::M_STRING) begin
					res[n] = sct_pkg::mk_res(sct_pkg::K_END, sct_pkg::ERR_STRING,
						sct_pkg::cap_line(32'(st_line_d)), sct_pkg::cap_col(32'(st_col_d)),
						'0, '0);
					n      = n + 2'd1;
					mode_d = sct_pkg::M_ERRSTR;
				end else if (sct_pkg::is_pending(mode_d)) begin
					res[n] = fin_res(mode_d, kw_d, st_line_d, st_col_d, st_off_d, byte_off_d);
					n      = n + 2'd1;
				end
			end
			if (mode_d == sct_pkg::M_ERRCHAR)
				code = sct_pkg::ERR_CHAR;
			else if (mode_d == sct_pkg::M_ERRSTR)
				code = sct_pkg::ERR_STRING;
			res[n] = sct_pkg::mk_res(sct_pkg::K_END, code, sct_pkg::cap_line(32'(cur_line_d)),
				sct_pkg::cap_col(32'(cur_col_d)), '0, '0);
			n      = n + 2'd1;
			// back to reset for the next source
			mode_d     = sct_pkg::M_IDLE;
			byte_off_d = '0;
			cur_line_d = '0;
			cur_col_d  = '0;
			st_off_d   = '0;
			st_line_d  = '0;
			st_col_d   = '0;
			kw_d       = 3'd0;
			pbs_d      = 1'b0;
			err_d      = 1'b0;
		end

		if (n != 2'd0)
			res[n - 2'd1].last_of_run = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= sct_pkg::M_IDLE;
			byte_off_q <= '0;
			cur_line_q <= '0;
			cur_col_q  <= '0;
			st_off_q   <= '0;
			st_line_q  <= '0;
			st_col_q   <= '0;
			kw_q       <= 3'd0;
			pbs_q      <= 1'b0;
			err_q      <= 1'b0;
		end else if (fire) begin
			mode_q     <= mode_d;
			byte_off_q <= byte_off_d;
			cur_line_q <= cur_line_d;
			cur_col_q  <= cur_col_d;
			st_off_q   <= st_off_d;
			st_line_q  <= st_line_d;
			st_col_q   <= st_col_d;
			kw_q       <= kw_d;
			pbs_q      <= pbs_d;
			err_q      <= err_d;
		end
	end

	assign push.item  = res;
	assign push.count = n;
	assign stat.mode  = mode_q;
	assign stat.err   = err_q;

endmodule

@@ rtl/sct_queue.sv @@
// result queue: takes up to three records a cycle, hands out one a cycle while pop is high and it is not empty
// depends on sct_pkg
module sct_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_en,
	input  sct_pkg::push_t push,
	input  logic           pop,
	output sct_pkg::res_t  head,
	output logic           not_empty,
	output logic           room
);

	localparam int PTR_W = $clog2(sct_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(sct_pkg::QUEUE_DEPTH + 1);

	sct_pkg::res_t    mem_q [sct_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_pop;
	logic [1:0]       n_push;

	assign not_empty = (cnt_q != '0);
	assign room      = (cnt_q <= CNT_W'(sct_pkg::QUEUE_DEPTH - sct_pkg::MAX_RESULTS));
	assign do_pop    = pop && not_empty;
	assign n_push    = push_en ? push.count : 2'd0;
	assign head      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_en) begin
			for (int i = 0; i < sct_pkg::MAX_RESULTS; i++) begin
				if (i < int'(push.count))
					mem_q[wr_ptr_q + PTR_W'(i)] <= push.item[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			cnt_q <= cnt_q + CNT_W'(n_push) - CNT_W'(do_pop);
		end
	end

endmodule

@@ rtl/source_code_tokenizer.sv @@
// top level of the source code tokenizer: byte channel in, token channel out
// depends on sct_pkg, sct_byte_if, sct_token_if, sct_scan, sct_queue and the assert header
//
// Streaming lexer: one source byte per transaction on text, one token record per
// transaction on token. A byte accepted in one cycle has its records in the result
// queue the next cycle; its first record appears on token once the records queued
// ahead of it have gone. The scanner handles one byte per cycle while the queue has
// room; the sustained rate is one byte per cycle as long as bytes give on average at
// most one record. A byte is taken only while the eight-entry result queue has three
// free places, so a byte that ends a token and is itself a symbol, or an end-of-source
// byte with its flush and end record, can make the queue fill and hold off input while
// the token side drains one record per cycle with token.ready high. last_of_run marks
// the final record of each byte; the end record (kind 19) closes each source and
// returns all position counters to zero. After reset the block takes input at once.
`include "source_code_tokenizer_assert.svh"

module source_code_tokenizer #(
	parameter int OFFSET_WIDTH = sct_pkg::DEF_OFFSET_WIDTH,
	parameter int LINE_WIDTH   = sct_pkg::DEF_LINE_WIDTH,
	parameter int COLUMN_WIDTH = sct_pkg::DEF_COLUMN_WIDTH
) (
	input  logic          clk,
	input  logic          arst_n,
	sct_byte_if.sink      text,
	sct_token_if.source   token
);

	sct_pkg::push_t push;
	sct_pkg::stat_t stat;
	sct_pkg::res_t  head;
	logic           fire;
	logic           room;
	logic           not_empty;

	// input transaction: taken only with room for the worst case of three records
	assign text.ready = room;
	assign fire       = text.valid && room;

	// scanner: mode, position counters and token start, one byte per cycle while the queue has room
	sct_scan #(
		.OFFSET_WIDTH (OFFSET_WIDTH),
		.LINE_WIDTH   (LINE_WIDTH),
		.COLUMN_WIDTH (COLUMN_WIDTH)
	) u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.fire          (fire),
		.source_byte   (text.source_byte),
		.end_of_source (text.end_of_source),
		.push          (push),
		.stat          (stat)
	);

	// result queue parts the scanner from the token side
	sct_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (fire),
		.push      (push),
		.pop       (token.ready),
		.head      (head),
		.not_empty (not_empty),
		.room      (room)
	);

	assign token.valid        = not_empty;
	assign token.token_kind   = head.token_kind;
	assign token.error_code   = head.error_code;
	assign token.token_line   = head.token_line;
	assign token.token_column = head.token_column;
	assign token.text_offset  = head.text_offset;
	assign token.text_length  = head.text_length;
	assign token.last_of_run  = head.last_of_run;

	// end of source always leaves at least its end record waiting
	`SCT_ASSERT_NXT(a_end_record, clk, arst_n, fire && text.end_of_source, token.valid)
	// end of source puts the scanner back to its reset state
	`SCT_ASSERT_NXT(a_end_clears, clk, arst_n, fire && text.end_of_source, stat.mode == sct_pkg::M_IDLE && !stat.err)
	// a latched error always sits in one of the two error modes
	`SCT_ASSERT_IMP(a_err_mode, clk, arst_n, stat.err, stat.mode == sct_pkg::M_ERRCHAR || stat.mode == sct_pkg::M_ERRSTR)

endmodule
